/* src/rbfe_pkg.sv */
// Package for the ring buffer frame extractor: sizes, field widths, codes,
// and the command/status structs between controller and datapath.
// No dependencies.
package rbfe_pkg;

  localparam int DEPTH      = 64;   // ring entries; holds at most DEPTH-1 bytes
  localparam int MAX_SYNC   = 4;    // longest sync token
  localparam int PTR_W      = $clog2(DEPTH);

  localparam int REQ_W      = 2;
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 8;
  localparam int STAT_W     = 3;
  localparam int FILL_OUT_W = 6;
  localparam int FLEN_W     = 6;
  localparam int SLEN_W     = 3;
  localparam int PAT_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int TOT_W      = LEN_W + 1;  // length byte + token + 1

  // request types
  localparam logic [REQ_W-1:0] REQ_PUSH   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK         = 3'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW   = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY      = 3'd2;
  localparam logic [STAT_W-1:0] ST_NO_FRAME   = 3'd3;
  localparam logic [STAT_W-1:0] ST_INCOMPLETE = 3'd4;
  localparam logic [STAT_W-1:0] ST_BAD_REQ    = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_PATTERN = 2'd1;

  typedef struct packed {
    logic latch;      // capture input transaction
    logic setup;      // decode request, do push, prepare pop/search
    logic rd_scan;    // read ring at scan pointer
    logic scan_step;  // evaluate one scanned byte
    logic rd_len;     // read frame length byte
    logic len_chk;    // check frame is fully stored
    logic rd_emit;    // read next byte to emit
    logic emit_ld;    // load output register with emitted byte
    logic send_ld;    // load output register with status-only result
  } ctl_cmd_t;

  typedef struct packed {
    logic go_single;  // request ends in one status result
    logic go_emit;    // request emits stored bytes right away
    logic hit;        // sync token matched at this byte
    logic scan_last;  // last scan position reached
    logic frame_ok;   // whole frame stored
    logic emit_done;  // no bytes left to emit
    logic out_free;   // output register can take a result
  } dp_sts_t;

endpackage

/* src/ring_buffer_frame_extractor.sv */
// Top level of the ring buffer frame extractor: controller plus datapath.
// Depends on rbfe_pkg, rbfe_ctrl and rbfe_dp.
//
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    req_type, data_byte, length_req, chunk_first
// out      output     out_valid / out_ready  out_byte, last, status, fill_count, frame_length
// cfg      input      cfg_valid / cfg_ready  cfg_index (0 sync_length, 1 sync_pattern), cfg_data
//
// Sequence: push runs accept, decode, result load. Pop of n bytes runs accept, decode, then a
//   read and an output load per byte. A search runs accept, decode, a read and a compare per
//   scanned byte, then a length read and check, and a read and load per frame byte if a frame
//   is found; a status-only result (bad or empty pop, failed search) ends in a load state. The
//   single ring read port with its registered read data makes each byte a read, then a load.
// Reset: rst_n synchronous, active low; clears pointers, chunk state and output valid and sets
//   config to sync length 1, pattern 128. Ring content is not cleared and needs no clearing pass.
// Stalls: out_ready low holds the sequencer before each result load; a result
//   waiting in the output register does not block the next input transaction.
// Config writes are taken in any cycle and take effect at once, busy or not;
//   write them only while the block is idle.
module ring_buffer_frame_extractor import rbfe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [REQ_W-1:0]      in_req_type,
  input  logic [BYTE_W-1:0]     in_data_byte,
  input  logic [LEN_W-1:0]      in_length_req,
  input  logic                  in_chunk_first,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [BYTE_W-1:0]     out_byte,
  output logic                  out_last,
  output logic [STAT_W-1:0]     out_status,
  output logic [FILL_OUT_W-1:0] out_fill_count,
  output logic [FLEN_W-1:0]     out_frame_length,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [PAT_W-1:0]      cfg_data
);

  ctl_cmd_t cmd;   // controller -> datapath
  dp_sts_t  sts;   // datapath -> controller

  // sequencer: one request at a time, walks scan and emit loops
  rbfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // ring memory, pointers, token matcher and output register
  rbfe_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_req_type      (in_req_type),
    .in_data_byte     (in_data_byte),
    .in_length_req    (in_length_req),
    .in_chunk_first   (in_chunk_first),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_last         (out_last),
    .out_status       (out_status),
    .out_fill_count   (out_fill_count),
    .out_frame_length (out_frame_length)
  );

endmodule

/* src/rbfe_ctrl.sv */
// Controller state machine of the ring buffer frame extractor.
// Depends on rbfe_pkg (command/status structs).
module rbfe_ctrl import rbfe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_SCAN_RD  = 4'd2;
  localparam logic [3:0] S_SCAN_CMP = 4'd3;
  localparam logic [3:0] S_LEN_RD   = 4'd4;
  localparam logic [3:0] S_LEN_CHK  = 4'd5;
  localparam logic [3:0] S_EMIT_RD  = 4'd6;
  localparam logic [3:0] S_EMIT_LD  = 4'd7;
  localparam logic [3:0] S_SEND     = 4'd8;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.setup = 1'b1;
        priority if (sts.go_single) state_nxt = S_SEND;
        else if (sts.go_emit)       state_nxt = S_EMIT_RD;
        else                        state_nxt = S_SCAN_RD;
      end
      S_SCAN_RD: begin
        cmd.rd_scan = 1'b1;
        state_nxt   = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        cmd.scan_step = 1'b1;
        priority if (sts.hit && !sts.scan_last) state_nxt = S_LEN_RD;
        else if (sts.hit || sts.scan_last)      state_nxt = S_SEND;
        else                                    state_nxt = S_SCAN_RD;
      end
      S_LEN_RD: begin
        cmd.rd_len = 1'b1;
        state_nxt  = S_LEN_CHK;
      end
      S_LEN_CHK: begin
        cmd.len_chk = 1'b1;
        state_nxt   = sts.frame_ok ? S_EMIT_RD : S_SEND;
      end
      S_EMIT_RD: begin
        if (sts.out_free) begin
          cmd.rd_emit = 1'b1;
          state_nxt   = S_EMIT_LD;
        end
      end
      S_EMIT_LD: begin
        cmd.emit_ld = 1'b1;
        state_nxt   = sts.emit_done ? S_IDLE : S_EMIT_RD;
      end
      S_SEND: begin
        if (sts.out_free) begin
          cmd.send_ld = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // a new transaction is only taken with nothing in flight
  a_latch_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch |=> state_r == S_DECODE)
    else $error("latch did not lead to decode");

  // every byte read for emission is followed by its output load
  a_emit_pair: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_emit |=> cmd.emit_ld)
    else $error("emit read without output load");

  // a length read only follows a token hit before the last position
  a_len_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_len |-> $past(cmd.scan_step && sts.hit && !sts.scan_last))
    else $error("length byte read without token hit");

endmodule

/* src/rbfe_dp.sv */
// Datapath of the ring buffer frame extractor: ring memory, pointers, chunk
// state, sync search, config registers and output register. Uses rbfe_pkg.
module rbfe_dp import rbfe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctl_cmd_t              cmd,
  output dp_sts_t               sts,
  input  logic [REQ_W-1:0]      in_req_type,
  input  logic [BYTE_W-1:0]     in_data_byte,
  input  logic [LEN_W-1:0]      in_length_req,
  input  logic                  in_chunk_first,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [PAT_W-1:0]      cfg_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [BYTE_W-1:0]     out_byte,
  output logic                  out_last,
  output logic [STAT_W-1:0]     out_status,
  output logic [FILL_OUT_W-1:0] out_fill_count,
  output logic [FLEN_W-1:0]     out_frame_length
);

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // (p - n) mod DEPTH, n < DEPTH
  function automatic logic [PTR_W-1:0] ptr_sub(input logic [PTR_W-1:0] p,
                                                input logic [PTR_W-1:0] n);
    logic [PTR_W:0] s;
    if (p >= n) s = {1'b0, p} - {1'b0, n};
    else        s = {1'b0, p} + (PTR_W+1)'(DEPTH) - {1'b0, n};
    return s[PTR_W-1:0];
  endfunction

  // token bytes past the pattern register read as zero
  function automatic logic [BYTE_W-1:0] token_byte(input logic [PAT_W-1:0] pat,
                                                    input int i);
    return BYTE_W'(pat >> (BYTE_W * i));
  endfunction

  // ring storage, content undefined until written
  logic [BYTE_W-1:0] ring_mem [DEPTH];
  logic [BYTE_W-1:0] mem_q_r;
  logic              rd_en, wr_en;
  logic [PTR_W-1:0]  rd_addr;

  // state
  logic [PTR_W-1:0]  rp_r, rp_nxt, wp_r, wp_nxt;
  logic [LEN_W-1:0]  chunk_left_r, chunk_left_nxt;
  logic              chunk_drop_r, chunk_drop_nxt;
  logic [SLEN_W-1:0] sync_length_r, sync_length_nxt;
  logic [PAT_W-1:0]  sync_pattern_r, sync_pattern_nxt;

  // captured request
  logic [REQ_W-1:0]  req_type_r;
  logic [BYTE_W-1:0] req_data_r;
  logic [LEN_W-1:0]  req_len_r;
  logic              req_first_r;

  // sequencing and pending result
  logic [PTR_W-1:0]    sa_r, sa_nxt;
  logic [PTR_W-1:0]    cnt_r, cnt_nxt;
  logic [MAX_SYNC-1:0] d_r, d_nxt;
  logic [STAT_W-1:0]   res_status_r, res_status_nxt;
  logic [PTR_W-1:0]    res_fill_r, res_fill_nxt;
  logic [FLEN_W-1:0]   res_flen_r, res_flen_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]     out_byte_r;
  logic                  out_last_r;
  logic [STAT_W-1:0]     out_status_r;
  logic [FILL_OUT_W-1:0] out_fill_r;
  logic [FLEN_W-1:0]     out_flen_r;

  // combinational helpers
  logic [PTR_W-1:0]    fill, tlm1, pop_n, sa_inc;
  logic [TOT_W-1:0]    fill9, tl9, total;
  logic                tl_bad, too_short;
  logic                push_store;
  logic [STAT_W-1:0]   push_status, single_status;
  logic [LEN_W-1:0]    push_cl;
  logic                push_drop;
  logic [MAX_SYNC-1:0] d_new;
  logic                hit, scan_last, frame_ok, go_single, go_emit;

  assign fill      = ptr_sub(wp_r, rp_r);
  assign fill9     = TOT_W'(fill);
  assign tl9       = TOT_W'(sync_length_r);
  assign tlm1      = PTR_W'(sync_length_r - SLEN_W'(1));
  assign sa_inc    = ptr_inc(sa_r);
  assign tl_bad    = (sync_length_r == '0) || (int'(sync_length_r) > MAX_SYNC);
  assign too_short = (tl9 + TOT_W'(1)) > fill9;
  assign pop_n     = (TOT_W'(req_len_r) < fill9) ? PTR_W'(req_len_r) : fill;
  assign total     = TOT_W'(mem_q_r) + tl9 + TOT_W'(1);
  assign frame_ok  = (fill9 >= total) && (total <= TOT_W'(DEPTH));
  assign scan_last = (cnt_r == PTR_W'(1));

  // push decision
  always_comb begin
    push_store  = 1'b0;
    push_status = ST_OK;
    push_cl     = chunk_left_r;
    push_drop   = chunk_drop_r;
    if (req_first_r) begin
      if (req_len_r == '0) begin
        push_status = ST_BAD_REQ;
        push_cl     = '0;
        push_drop   = 1'b0;
      end else begin
        push_cl = req_len_r - LEN_W'(1);
        if (fill9 + TOT_W'(req_len_r) > TOT_W'(DEPTH - 1)) begin
          push_drop   = 1'b1;
          push_status = ST_OVERFLOW;
        end else begin
          push_drop  = 1'b0;
          push_store = 1'b1;
        end
      end
    end else if (chunk_left_r == '0) begin
      push_status = ST_BAD_REQ;
    end else begin
      push_cl = chunk_left_r - LEN_W'(1);
      if (chunk_drop_r || fill == PTR_W'(DEPTH - 1)) push_status = ST_OVERFLOW;
      else                                           push_store  = 1'b1;
    end
  end

  // request classification
  always_comb begin
    go_single     = 1'b1;
    single_status = ST_BAD_REQ;
    unique case (req_type_r)
      REQ_PUSH: single_status = push_status;
      REQ_POP: begin
        go_single     = (req_len_r == '0) || (fill == '0);
        single_status = (req_len_r == '0) ? ST_BAD_REQ : ST_EMPTY;
      end
      REQ_SEARCH: begin
        go_single     = tl_bad || too_short;
        single_status = tl_bad ? ST_BAD_REQ : ST_NO_FRAME;
      end
      default: single_status = ST_BAD_REQ;
    endcase
    go_emit = (req_type_r == REQ_POP) && !go_single;
  end

  // shift-and token match, one ring byte per step
  always_comb begin
    d_new[0] = (mem_q_r == token_byte(sync_pattern_r, 0));
    for (int i = 1; i < MAX_SYNC; i++) begin
      d_new[i] = d_r[i-1] & (mem_q_r == token_byte(sync_pattern_r, i));
    end
    hit = 1'b0;
    for (int i = 0; i < MAX_SYNC; i++) begin
      if (int'(sync_length_r) == i + 1) hit = d_new[i];
    end
  end

  // memory port control
  assign wr_en = cmd.setup && (req_type_r == REQ_PUSH) && push_store;
  assign rd_en = cmd.rd_scan || cmd.rd_len || cmd.rd_emit;
  always_comb begin
    priority if (cmd.rd_scan) rd_addr = sa_r;
    else if (cmd.rd_len)      rd_addr = sa_inc;
    else                      rd_addr = rp_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) ring_mem[wp_r] <= req_data_r;
    if (rd_en) mem_q_r <= ring_mem[rd_addr];
  end

  // next state
  always_comb begin
    rp_nxt           = rp_r;
    wp_nxt           = wp_r;
    chunk_left_nxt   = chunk_left_r;
    chunk_drop_nxt   = chunk_drop_r;
    sync_length_nxt  = sync_length_r;
    sync_pattern_nxt = sync_pattern_r;
    sa_nxt           = sa_r;
    cnt_nxt          = cnt_r;
    d_nxt            = d_r;
    res_status_nxt   = res_status_r;
    res_fill_nxt     = res_fill_r;
    res_flen_nxt     = res_flen_r;

    if (cfg_valid) begin
      if (cfg_index == REG_SYNC_LENGTH)       sync_length_nxt  = cfg_data[SLEN_W-1:0];
      else if (cfg_index == REG_SYNC_PATTERN) sync_pattern_nxt = cfg_data;
    end

    if (cmd.setup) begin
      res_status_nxt = single_status;
      if (req_type_r == REQ_PUSH) begin
        chunk_left_nxt = push_cl;
        chunk_drop_nxt = push_drop;
        if (push_store) wp_nxt = ptr_inc(wp_r);
      end
      if (go_emit) begin
        cnt_nxt        = pop_n;
        res_status_nxt = ST_OK;
        res_flen_nxt   = '0;
        res_fill_nxt   = fill - pop_n;
      end
      if (req_type_r == REQ_SEARCH && !go_single) begin
        sa_nxt  = rp_r;
        cnt_nxt = fill - PTR_W'(1);   // scan positions 0 .. fill-2
        d_nxt   = '0;
      end
    end

    if (cmd.scan_step) begin
      d_nxt   = d_new;
      cnt_nxt = cnt_r - PTR_W'(1);
      if (hit) begin
        rp_nxt = ptr_sub(sa_r, tlm1);   // drop bytes before the token
        if (scan_last) res_status_nxt = ST_INCOMPLETE;
      end else if (scan_last) begin
        rp_nxt         = ptr_sub(sa_inc, tlm1);
        res_status_nxt = ST_NO_FRAME;
      end else begin
        sa_nxt = sa_inc;
      end
    end

    if (cmd.len_chk) begin
      if (frame_ok) begin
        cnt_nxt        = PTR_W'(total);
        res_status_nxt = ST_OK;
        res_flen_nxt   = FLEN_W'(total);
        res_fill_nxt   = fill - PTR_W'(total);
      end else begin
        res_status_nxt = ST_INCOMPLETE;
      end
    end

    if (cmd.rd_emit) begin
      rp_nxt  = ptr_inc(rp_r);
      cnt_nxt = cnt_r - PTR_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.emit_ld || cmd.send_ld) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r           <= '0;
      wp_r           <= '0;
      chunk_left_r   <= '0;
      chunk_drop_r   <= 1'b0;
      sync_length_r  <= SLEN_W'(1);
      sync_pattern_r <= PAT_W'(128);
      out_valid_r    <= 1'b0;
    end else begin
      rp_r           <= rp_nxt;
      wp_r           <= wp_nxt;
      chunk_left_r   <= chunk_left_nxt;
      chunk_drop_r   <= chunk_drop_nxt;
      sync_length_r  <= sync_length_nxt;
      sync_pattern_r <= sync_pattern_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_type_r  <= in_req_type;
      req_data_r  <= in_data_byte;
      req_len_r   <= in_length_req;
      req_first_r <= in_chunk_first;
    end
    sa_r         <= sa_nxt;
    cnt_r        <= cnt_nxt;
    d_r          <= d_nxt;
    res_status_r <= res_status_nxt;
    res_fill_r   <= res_fill_nxt;
    res_flen_r   <= res_flen_nxt;
    if (cmd.emit_ld) begin
      out_byte_r   <= mem_q_r;
      out_last_r   <= (cnt_r == '0);
      out_status_r <= res_status_r;
      out_fill_r   <= FILL_OUT_W'(res_fill_r);
      out_flen_r   <= res_flen_r;
    end else if (cmd.send_ld) begin
      out_byte_r   <= '0;
      out_last_r   <= 1'b1;
      out_status_r <= res_status_r;
      out_fill_r   <= FILL_OUT_W'(fill);
      out_flen_r   <= '0;
    end
  end

  assign sts.go_single = go_single;
  assign sts.go_emit   = go_emit;
  assign sts.hit       = hit;
  assign sts.scan_last = scan_last;
  assign sts.frame_ok  = frame_ok;
  assign sts.emit_done = (cnt_r == '0);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_last         = out_last_r;
  assign out_status       = out_status_r;
  assign out_fill_count   = out_fill_r;
  assign out_frame_length = out_flen_r;

  // output register is never overwritten while it holds an untaken result
  a_out_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_ld || cmd.send_ld) |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");

  // a stored byte always leaves the ring non-empty
  a_store_fill: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> fill != '0)
    else $error("ring empty after store");

  // emission never reads past the stored bytes
  a_emit_stored: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_emit |-> fill != '0)
    else $error("emit from empty ring");

endmodule
